FILE: hw/rtl/nvi_pkg.sv
// ----------------------------------------------------------------------------
// nvi_pkg
// shared types, constants and saturation helpers of the neville interpolator
// ----------------------------------------------------------------------------
package nvi_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int QW        = 32;
  localparam int DivW      = 48;   // |w| * 2^16
  localparam int InDataW   = 96;   // sample_x, sample_y, query_x
  localparam int OutDataW  = 72;   // interp_value, error_estimate, status, pad

  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StDup   = 2'd2
  } status_e;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic q_start;
    logic scan_use;
    logic step_prep;
    logic div_start;
    logic mul_hp;
    logic mul_ho;
    logic wr_c;
    logic dy_rd;
    logic dy_use;
    logic fin_ok;
    logic fin_empty;
    logic fin_dup;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic order_end;
    logic step_last;
    logic order_last;
    logic den_zero;
    logic div_done;
    logic out_full;
  } sts_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > QMax) begin
      r = QMax[QW-1:0];
    end else if (v < QMin) begin
      r = QMin[QW-1:0];
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // signed, saturated quotient from magnitude and sign
  function automatic logic signed [QW-1:0] sat_quot(input logic [DivW-1:0] mag,
                                                    input logic neg);
    logic signed [63:0] v;
    v = $signed({{(64 - DivW){1'b0}}, mag});
    if (neg) begin
      v = -v;
    end
    return sat_q(v);
  endfunction

endpackage

FILE: hw/rtl/nvi_div.sv
// ----------------------------------------------------------------------------
// nvi_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nvi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [nvi_pkg::DivW-1:0]  dividend_i,
  input  logic [nvi_pkg::QW-1:0]    divisor_i,
  output logic                      done_o,
  output logic [nvi_pkg::DivW-1:0]  quotient_o
);

  localparam int CntBits = $clog2(nvi_pkg::DivW);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CntBits-1:0]       cnt_q, cnt_d;
  logic [nvi_pkg::QW:0]     rem_q, rem_d;
  logic [nvi_pkg::DivW-1:0] quo_q, quo_d;
  logic [nvi_pkg::QW-1:0]   dvs_q, dvs_d;
  logic [nvi_pkg::QW:0]     rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[nvi_pkg::QW-1:0], quo_q[nvi_pkg::DivW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[nvi_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[nvi_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(nvi_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/nvi_dp.sv
// ----------------------------------------------------------------------------
// nvi_dp
// datapath: point stores, tableau columns, index counters, multiplier, output
// ----------------------------------------------------------------------------
module nvi_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nvi_pkg::cmd_t                   cmd_i,
  output nvi_pkg::sts_t                   sts_o,
  input  logic signed [nvi_pkg::QW-1:0]   sample_x_i,
  input  logic signed [nvi_pkg::QW-1:0]   sample_y_i,
  input  logic signed [nvi_pkg::QW-1:0]   query_x_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [nvi_pkg::QW-1:0]   interp_value_o,
  output logic signed [nvi_pkg::QW-1:0]   error_estimate_o,
  output logic [1:0]                      status_o
);

  localparam int IdxW = nvi_pkg::IdxW;
  localparam int CntW = nvi_pkg::CntW;
  localparam int QW   = nvi_pkg::QW;

  logic signed [QW-1:0] x_mem [nvi_pkg::MaxPoints];
  logic signed [QW-1:0] y_mem [nvi_pkg::MaxPoints];
  logic signed [QW-1:0] c_mem [nvi_pkg::MaxPoints];
  logic signed [QW-1:0] d_mem [nvi_pkg::MaxPoints];

  logic signed [QW-1:0] xa_rd_q, xb_rd_q, y_rd_q, c_rd_q, d_rd_q;

  logic [CntW-1:0] count_q, n_q, m_q;
  logic [IdxW-1:0] i_q, k_q;
  logic [QW:0]     best_q;
  logic signed [QW-1:0] qx_q, y_q, dy_q, ho_q, hp_q, w_q, den_q;
  logic            neg_q, sel_c_q;
  logic signed [63:0] prod_q;
  logic            out_valid_q;
  logic signed [QW-1:0] val_q, est_q;
  logic [1:0]      st_q;

  logic [IdxW-1:0] xb_addr, c_addr, d_addr;
  logic signed [QW:0] dist_s;
  logic [QW:0]     dist_mag;
  logic            full;
  logic            div_done;
  logic [nvi_pkg::DivW-1:0] quot;
  logic signed [QW-1:0] q_sat, tab_val, dy_sel, w_abs, den_abs;
  logic            c_we, d_we;
  logic signed [QW-1:0] c_wd;

  assign full     = (count_q == CntW'(nvi_pkg::MaxPoints));
  assign xb_addr  = i_q + m_q[IdxW-1:0];
  assign c_addr   = cmd_i.dy_rd ? k_q : i_q + IdxW'(1);
  assign d_addr   = cmd_i.dy_rd ? k_q - IdxW'(1) : i_q;
  assign dist_s   = (QW+1)'(qx_q) - (QW+1)'(xa_rd_q);
  assign dist_mag = dist_s[QW] ? (QW+1)'(-dist_s) : dist_s;
  assign q_sat    = nvi_pkg::sat_quot(quot, neg_q);
  assign tab_val  = nvi_pkg::sat_q(prod_q >>> 16);
  assign dy_sel   = sel_c_q ? c_rd_q : d_rd_q;
  assign w_abs    = w_q[QW-1] ? -w_q : w_q;
  assign den_abs  = den_q[QW-1] ? -den_q : den_q;

  // store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      x_mem[count_q[IdxW-1:0]] <= sample_x_i;
      y_mem[count_q[IdxW-1:0]] <= sample_y_i;
    end
    xa_rd_q <= x_mem[i_q];
    xb_rd_q <= x_mem[xb_addr];
    y_rd_q  <= y_mem[i_q];
  end

  assign c_we = cmd_i.scan_use || cmd_i.wr_c;
  assign d_we = cmd_i.scan_use || cmd_i.mul_ho;
  assign c_wd = cmd_i.scan_use ? y_rd_q : tab_val;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[i_q] <= c_wd;
    end
    if (d_we) begin
      d_mem[i_q] <= c_wd;
    end
    c_rd_q <= c_mem[c_addr];
    d_rd_q <= d_mem[d_addr];
  end

  nvi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({w_abs, 16'h0000}),
    .divisor_i  (den_abs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && !full) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.q_start) begin
        count_q <= '0;
      end
      if (cmd_i.fin_ok || cmd_i.fin_empty || cmd_i.fin_dup) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // query working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      n_q  <= count_q;
      qx_q <= query_x_i;
      i_q  <= '0;
      m_q  <= CntW'(1);
      k_q  <= '0;
      dy_q <= '0;
    end
    if (cmd_i.scan_use) begin
      if (i_q == '0 || dist_mag < best_q) begin
        best_q <= dist_mag;
        k_q    <= i_q;
        y_q    <= y_rd_q;
      end
      i_q <= sts_o.scan_last ? '0 : i_q + 1'b1;
    end
    if (cmd_i.step_prep) begin
      ho_q  <= nvi_pkg::sat_q(64'(xa_rd_q) - 64'(qx_q));
      hp_q  <= nvi_pkg::sat_q(64'(xb_rd_q) - 64'(qx_q));
      w_q   <= nvi_pkg::sat_q(64'(c_rd_q) - 64'(d_rd_q));
      den_q <= nvi_pkg::sat_q(64'(xa_rd_q) - 64'(xb_rd_q));
    end
    if (cmd_i.div_start) begin
      neg_q <= w_q[QW-1] ^ den_q[QW-1];
    end
    if (cmd_i.mul_hp) begin
      prod_q <= 64'(hp_q) * 64'(q_sat);
    end
    if (cmd_i.mul_ho) begin
      prod_q <= 64'(ho_q) * 64'(q_sat);
    end
    if (cmd_i.wr_c) begin
      i_q <= sts_o.step_last ? '0 : i_q + 1'b1;
    end
    if (cmd_i.dy_rd) begin
      sel_c_q <= ({1'b0, k_q, 1'b0} < (IdxW+2)'(n_q - m_q));
    end
    if (cmd_i.dy_use) begin
      dy_q <= dy_sel;
      y_q  <= nvi_pkg::sat_q(64'(y_q) + 64'(dy_sel));
      if (!sel_c_q) begin
        k_q <= k_q - 1'b1;
      end
      m_q <= m_q + 1'b1;
      i_q <= '0;
    end
    if (cmd_i.fin_ok) begin
      val_q <= y_q;
      est_q <= dy_q;
      st_q  <= nvi_pkg::StOk;
    end else if (cmd_i.fin_empty) begin
      val_q <= '0;
      est_q <= '0;
      st_q  <= nvi_pkg::StEmpty;
    end else if (cmd_i.fin_dup) begin
      val_q <= '0;
      est_q <= '0;
      st_q  <= nvi_pkg::StDup;
    end
  end

  always_comb begin
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.scan_last  = ((CntW'(i_q) + CntW'(1)) == n_q);
    sts_o.order_end  = (m_q == n_q);
    sts_o.step_last  = ((CntW'(i_q) + m_q + CntW'(1)) == n_q);
    sts_o.order_last = ((m_q + CntW'(1)) == n_q);
    sts_o.den_zero   = (den_q == '0);
    sts_o.div_done   = div_done;
    sts_o.out_full   = out_valid_q;
  end

  assign out_valid_o      = out_valid_q;
  assign interp_value_o   = val_q;
  assign error_estimate_o = est_q;
  assign status_o         = st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(nvi_pkg::MaxPoints))
    else $error("point count beyond store depth");

  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> den_q != '0)
    else $error("divider started on zero divisor");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.q_start |=> count_q == '0)
    else $error("point count not cleared by query");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fin_ok || cmd_i.fin_empty || cmd_i.fin_dup) |-> !out_valid_q)
    else $error("result written over a pending beat");

endmodule

FILE: hw/rtl/nvi_ctrl.sv
// ----------------------------------------------------------------------------
// nvi_ctrl
// controller state machine sequencing scan, tableau steps and result
// ----------------------------------------------------------------------------
module nvi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  input  nvi_pkg::sts_t sts_i,
  output nvi_pkg::cmd_t cmd_o
);

  typedef enum logic [14:0] {
    SIdle    = 15'b000000000000001,
    SScanRd  = 15'b000000000000010,
    SScanUse = 15'b000000000000100,
    SStepRd  = 15'b000000000001000,
    SStepPrp = 15'b000000000010000,
    SDivGo   = 15'b000000000100000,
    SDivWait = 15'b000000001000000,
    SMulHp   = 15'b000000010000000,
    SMulHo   = 15'b000000100000000,
    SWrC     = 15'b000001000000000,
    SDyRd    = 15'b000010000000000,
    SDyUse   = 15'b000100000000000,
    SFinOk   = 15'b001000000000000,
    SFinEmp  = 15'b010000000000000,
    SFinDup  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (in_kind_i == nvi_pkg::KindQuery) begin
            cmd_o.q_start = 1'b1;
            state_d = sts_i.cnt_zero ? SFinEmp : SScanRd;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      SScanRd: state_d = SScanUse;
      SScanUse: begin
        cmd_o.scan_use = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.order_end ? SFinOk : SStepRd;
        end else begin
          state_d = SScanRd;
        end
      end
      SStepRd: state_d = SStepPrp;
      SStepPrp: begin
        cmd_o.step_prep = 1'b1;
        state_d = SDivGo;
      end
      SDivGo: begin
        if (sts_i.den_zero) begin
          state_d = SFinDup;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = SDivWait;
        end
      end
      SDivWait: begin
        if (sts_i.div_done) begin
          state_d = SMulHp;
        end
      end
      SMulHp: begin
        cmd_o.mul_hp = 1'b1;
        state_d = SMulHo;
      end
      SMulHo: begin
        cmd_o.mul_ho = 1'b1;
        state_d = SWrC;
      end
      SWrC: begin
        cmd_o.wr_c = 1'b1;
        state_d = sts_i.step_last ? SDyRd : SStepRd;
      end
      SDyRd: begin
        cmd_o.dy_rd = 1'b1;
        state_d = SDyUse;
      end
      SDyUse: begin
        cmd_o.dy_use = 1'b1;
        state_d = sts_i.order_last ? SFinOk : SStepRd;
      end
      SFinOk: begin
        if (!sts_i.out_full) begin
          cmd_o.fin_ok = 1'b1;
          state_d = SIdle;
        end
      end
      SFinEmp: begin
        if (!sts_i.out_full) begin
          cmd_o.fin_empty = 1'b1;
          state_d = SIdle;
        end
      end
      SFinDup: begin
        if (!sts_i.out_full) begin
          cmd_o.fin_dup = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/neville_polynomial_interpolator.sv
// ----------------------------------------------------------------------------
// neville_polynomial_interpolator
// signed q16.16 neville interpolation over up to sixteen stored points
// ----------------------------------------------------------------------------
// load beats (tuser 0) store one sample point each; points past the
// sixteenth are dropped. a query beat (tuser 1) picks the stored point nearest
// the query as the start value, runs the tableau over all points and returns
// one result beat with the value, the last correction and a status; the point
// count is cleared when the query is accepted. each tableau step is bound by
// the serial divider. the input is refused while a query runs; a finished
// result sits in the output register and the next item is accepted while it
// waits.
module neville_polynomial_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample_x [31:0], sample_y [63:32], query_x [95:64]
  input  logic [nvi_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind: 0 load point, 1 query
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // interp_value [31:0], error_estimate [63:32], status [65:64], zero pad
  output logic [nvi_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);

  localparam int QW = nvi_pkg::QW;

  nvi_pkg::cmd_t cmd;
  nvi_pkg::sts_t sts;
  logic signed [QW-1:0] interp_value, error_estimate;
  logic [1:0] status;

  // controller: owns the handshake on the input side
  nvi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: stores, tableau arithmetic and the output register
  nvi_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_x_i       (s_axis_tdata_i[QW-1:0]),
    .sample_y_i       (s_axis_tdata_i[2*QW-1:QW]),
    .query_x_i        (s_axis_tdata_i[3*QW-1:2*QW]),
    .out_ready_i      (m_axis_tready_i),
    .out_valid_o      (m_axis_tvalid_o),
    .interp_value_o   (interp_value),
    .error_estimate_o (error_estimate),
    .status_o         (status)
  );

  // pack the result beat, zero pad up to whole bytes
  assign m_axis_tdata_o = {{(nvi_pkg::OutDataW - 2*QW - 2){1'b0}},
                           status, error_estimate, interp_value};

endmodule
